// ===== sv/assembly_token_lexer_core_defines.svh =====
// Assertion macros used by the checker file of the token lexer.
`ifndef ASSEMBLY_TOKEN_LEXER_CORE_DEFINES_SVH
`define ASSEMBLY_TOKEN_LEXER_CORE_DEFINES_SVH

// Implication in the same cycle.
`define ATL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication into the next cycle.
`define ATL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/atl_pkg.sv =====
// ----------------------------------------------------------------------------
// atl_pkg
// Types, codes, tables and character helpers of the assembly token lexer.
// ----------------------------------------------------------------------------
package atl_pkg;

   localparam int NAME_MAX_LEN_DEF = 128;
   localparam int REG_COUNT_DEF    = 16;
   localparam int MNEM_COUNT       = 46;
   localparam int RES_MAX          = 3;

   localparam logic [2:0] LIMIT_NONE = 3'd7;

   // lexer modes
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_NAME    = 3'd1;
   localparam logic [2:0] MODE_REG     = 3'd2;
   localparam logic [2:0] MODE_NUM     = 3'd3;
   localparam logic [2:0] MODE_POPEN   = 3'd4;
   localparam logic [2:0] MODE_TILDE   = 3'd5;
   localparam logic [2:0] MODE_COMMENT = 3'd6;

   // event codes
   localparam logic [2:0] EV_MNEM     = 3'd0;
   localparam logic [2:0] EV_REG      = 3'd1;
   localparam logic [2:0] EV_LIT      = 3'd2;
   localparam logic [2:0] EV_MEM      = 3'd3;
   localparam logic [2:0] EV_LABEL    = 3'd4;
   localparam logic [2:0] EV_COMPLETE = 3'd5;
   localparam logic [2:0] EV_END      = 3'd6;
   localparam logic [2:0] EV_ERROR    = 3'd7;

   // error codes
   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_BAD_CHAR  = 4'd1;
   localparam logic [3:0] ERR_BAD_REG   = 4'd2;
   localparam logic [3:0] ERR_MISPLACED = 4'd3;
   localparam logic [3:0] ERR_COMMA     = 4'd4;
   localparam logic [3:0] ERR_COMMENT   = 4'd5;
   localparam logic [3:0] ERR_NO_CLOSE  = 4'd6;
   localparam logic [3:0] ERR_NO_COLON  = 4'd7;
   localparam logic [3:0] ERR_TOO_LONG  = 4'd8;
   localparam logic [3:0] ERR_STRAY     = 4'd9;

   // operand kinds
   localparam logic [1:0] KIND_R  = 2'd1;
   localparam logic [1:0] KIND_I  = 2'd2;
   localparam logic [1:0] KIND_DF = 2'd3;

   typedef struct packed {
      logic [2:0]  mode;
      logic [39:0] name_chars;   // first five chars, newest in the low byte
      logic [7:0]  name_len;
      logic [7:0]  name_last;
      logic [31:0] dec_value;
      logic [31:0] hex_value;
      logic [3:0]  num_flags;
      logic        in_paren;
      logic [2:0]  place;
      logic [2:0]  limit;
      logic [5:0]  fmt;
      logic [1:0]  slot;
      logic        halted;
   } lex_state_type;

   localparam lex_state_type LEX_RESET = '{
      mode: MODE_IDLE, name_chars: '0, name_len: '0, name_last: '0,
      dec_value: '0, hex_value: '0, num_flags: '0, in_paren: 1'b0,
      place: '0, limit: LIMIT_NONE, fmt: '0, slot: '0, halted: 1'b0};

   typedef struct packed {
      logic [2:0]  event_res;
      logic [31:0] value;
      logic        mem_is_register;
      logic [5:0]  operand_format;
      logic [3:0]  error_code;
   } result_type;

   localparam logic [31:0] MNEM_TEXT [MNEM_COUNT] = '{
      "lvr", "lvrx", "add", "addx", "sub", "subx", "mul", "mulx", "div", "divx",
      "lfp", "lfpx", "int", "lpi", "lpix", "lpo", "lpox", "slv", "slvx", "vts",
      "vtsx", "vfs", "vfsx", "ret", "jmp", "jpr", "jeq", "jls", "jgr", "jle",
      "jge", "jzo", "jcr", "jne", "com", "comx", "and", "andx", "or", "orx",
      "xor", "xorx", "sfl", "sflx", "sfr", "sfrx"};

   localparam logic [2:0] MNEM_LIMIT [MNEM_COUNT] = '{
      3'd4, 3'd4, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6,
      3'd4, 3'd4, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd2,
      3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
      3'd2, 3'd2, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
      3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4};

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_xdigit(input logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [3:0] xval(input logic [7:0] c);
      logic [7:0] t;
      if (is_digit(c)) t = c - 8'd48;
      else if (c >= "a" && c <= "f") t = c - 8'd87;
      else t = c - 8'd55;
      return t[3:0];
   endfunction

   // {found, index}; the lowest matching entry wins
   function automatic logic [6:0] mnem_lookup(input logic [39:0] chars,
                                              input logic [7:0] len);
      logic       found;
      logic [5:0] idx;
      found = 1'b0;
      idx   = '0;
      for (int k = 0; k < MNEM_COUNT; k++) begin
         if (!found && len >= 8'd1 && len <= 8'd4 && chars[39:32] == 8'd0 &&
             chars[31:0] == MNEM_TEXT[k]) begin
            found = 1'b1;
            idx   = 6'(k);
         end
      end
      return {found, idx};
   endfunction

   function automatic result_type mk_result(input logic [2:0] ev,
                                            input logic [31:0] val,
                                            input logic memreg,
                                            input logic [5:0] fmt,
                                            input logic [3:0] code);
      result_type r;
      r.event_res       = ev;
      r.value           = val;
      r.mem_is_register = memreg;
      r.operand_format  = fmt;
      r.error_code      = code;
      return r;
   endfunction

endpackage

// ===== sv/atl_intf.sv =====
// ----------------------------------------------------------------------------
// atl_req_if / atl_rsp_if
// Valid/ready channels for source bytes and lexer results.
// ----------------------------------------------------------------------------
interface atl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   modport source (output valid, output ch, input ready);
   modport sink (input valid, input ch, output ready);
endinterface

interface atl_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [31:0] value;
   logic        mem_is_register;
   logic [5:0]  operand_format;
   logic [3:0]  error_code;
   logic        last;
   modport source (output valid, output event_res, output value, output mem_is_register,
                   output operand_format, output error_code, output last, input ready);
   modport sink (input valid, input event_res, input value, input mem_is_register,
                 input operand_format, input error_code, input last, output ready);
endinterface

// ===== sv/atl_lexer.sv =====
// ----------------------------------------------------------------------------
// atl_lexer
// Lexer state register and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module atl_lexer #(
   parameter int NAME_MAX_LEN = atl_pkg::NAME_MAX_LEN_DEF,
   parameter int REG_COUNT    = atl_pkg::REG_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          ch,
   output atl_pkg::result_type res [atl_pkg::RES_MAX],
   output logic [1:0]          res_count
);

   atl_pkg::lex_state_type st_ff, st_in;

   always_comb begin
      atl_pkg::lex_state_type s;
      logic [1:0]  n;
      logic        redo, do_idle, cc, fail, opk;
      logic [3:0]  code;
      logic [1:0]  kind;
      logic [6:0]  mk;
      logic [6:0]  ridx;
      logic        rok;
      logic [31:0] v;
      logic [1:0]  phase;
      logic [7:0]  c0, c1, c2;

      s       = st_ff;
      n       = '0;
      redo    = 1'b0;
      do_idle = 1'b0;
      cc      = 1'b0;
      fail    = 1'b0;
      opk     = 1'b0;
      code    = atl_pkg::ERR_NONE;
      kind    = '0;
      ridx    = '0;
      rok     = 1'b0;
      v       = '0;
      phase   = '0;
      c0      = st_ff.name_chars[7:0];
      c1      = st_ff.name_chars[15:8];
      c2      = st_ff.name_chars[23:16];
      mk      = atl_pkg::mnem_lookup(st_ff.name_chars, st_ff.name_len);
      for (int i = 0; i < atl_pkg::RES_MAX; i++) res[i] = '0;

      if (!st_ff.halted) begin
         case (st_ff.mode)
            atl_pkg::MODE_NAME: begin
               if (atl_pkg::is_alpha(ch) || atl_pkg::is_digit(ch) || ch == "_" ||
                   ch == ":") begin
                  if (s.name_len >= 8'(NAME_MAX_LEN - 1)) begin
                     fail = 1'b1;
                     code = atl_pkg::ERR_TOO_LONG;
                  end else begin
                     if (s.name_len < 8'd5) s.name_chars = {s.name_chars[31:0], ch};
                     if (s.name_len < 8'd255) s.name_len = s.name_len + 8'd1;
                     s.name_last = ch;
                  end
               end else if (!mk[6] && s.name_last != ":") begin
                  fail = 1'b1;
                  code = atl_pkg::ERR_NO_COLON;
               end else begin
                  if (s.limit != atl_pkg::LIMIT_NONE && s.place == s.limit) begin
                     res[n] = atl_pkg::mk_result(atl_pkg::EV_COMPLETE, '0, 1'b0, s.fmt,
                                                 atl_pkg::ERR_NONE);
                     n = n + 2'd1;
                     s.place = '0;
                     s.limit = atl_pkg::LIMIT_NONE;
                     s.fmt   = '0;
                     s.slot  = '0;
                  end
                  if (mk[6]) begin
                     s.limit = atl_pkg::MNEM_LIMIT[mk[5:0]];
                     if (s.place < 3'd7) s.place = s.place + 3'd1;
                     res[n] = atl_pkg::mk_result(atl_pkg::EV_MNEM, 32'(mk[5:0]), 1'b0,
                                                 '0, atl_pkg::ERR_NONE);
                  end else begin
                     res[n] = atl_pkg::mk_result(atl_pkg::EV_LABEL,
                                                 32'(s.name_len - 8'd1), 1'b0, '0,
                                                 atl_pkg::ERR_NONE);
                  end
                  n = n + 2'd1;
                  s.mode = atl_pkg::MODE_IDLE;
                  redo   = 1'b1;
               end
            end
            atl_pkg::MODE_REG: begin
               if (atl_pkg::is_alpha(ch) || atl_pkg::is_digit(ch)) begin
                  if (s.name_len < 8'd5) s.name_chars = {s.name_chars[31:0], ch};
                  if (s.name_len < 8'd255) s.name_len = s.name_len + 8'd1;
                  s.name_last = ch;
               end else begin
                  if (s.name_len == 8'd2 && c1 == "r" && atl_pkg::is_digit(c0)) begin
                     ridx = 7'(c0 - 8'd48);
                     rok  = 1'b1;
                  end else if (s.name_len == 8'd3 && c2 == "r" && c1 >= "1" &&
                               c1 <= "9" && atl_pkg::is_digit(c0)) begin
                     ridx = 7'((c1 - 8'd48) * 8'd10 + (c0 - 8'd48));
                     rok  = 1'b1;
                  end
                  rok    = rok && (ridx < 7'(REG_COUNT));
                  s.mode = atl_pkg::MODE_IDLE;
                  if (!rok) begin
                     fail = 1'b1;
                     code = atl_pkg::ERR_BAD_REG;
                  end else if (s.in_paren && ch != ")") begin
                     fail = 1'b1;
                     code = atl_pkg::ERR_NO_CLOSE;
                  end else begin
                     if (s.place < 3'd7) s.place = s.place + 3'd1;
                     if (s.in_paren) begin
                        res[n] = atl_pkg::mk_result(atl_pkg::EV_MEM, 32'(ridx), 1'b1, '0,
                                                    atl_pkg::ERR_NONE);
                     end else begin
                        res[n] = atl_pkg::mk_result(atl_pkg::EV_REG, 32'(ridx), 1'b0, '0,
                                                    atl_pkg::ERR_NONE);
                        redo = 1'b1;
                     end
                     n = n + 2'd1;
                  end
               end
            end
            atl_pkg::MODE_NUM: begin
               if (atl_pkg::is_xdigit(ch) || ch == "x") begin
                  phase = s.num_flags[1:0];
                  if (!s.num_flags[2]) begin
                     if (atl_pkg::is_digit(ch))
                        s.dec_value = (s.dec_value << 3) + (s.dec_value << 1) +
                                      32'(ch - 8'd48);
                     else s.num_flags[2] = 1'b1;
                  end
                  if (phase == 2'd0) phase = (ch == "0") ? 2'd1 : 2'd2;
                  else if (phase == 2'd1) phase = (ch == "x") ? 2'd3 : 2'd2;
                  else if (phase == 2'd3 && !s.num_flags[3]) begin
                     if (atl_pkg::is_xdigit(ch))
                        s.hex_value = {s.hex_value[27:0], atl_pkg::xval(ch)};
                     else s.num_flags[3] = 1'b1;
                  end
                  s.num_flags[1:0] = phase;
               end else begin
                  s.mode = atl_pkg::MODE_IDLE;
                  v = (s.num_flags[1:0] == 2'd3) ? s.hex_value : s.dec_value;
                  if (s.in_paren && ch != ")") begin
                     fail = 1'b1;
                     code = atl_pkg::ERR_NO_CLOSE;
                  end else begin
                     if (s.place < 3'd7) s.place = s.place + 3'd1;
                     if (s.in_paren) begin
                        res[n] = atl_pkg::mk_result(atl_pkg::EV_MEM, v, 1'b0, '0,
                                                    atl_pkg::ERR_NONE);
                     end else begin
                        res[n] = atl_pkg::mk_result(atl_pkg::EV_LIT, v, 1'b0, '0,
                                                    atl_pkg::ERR_NONE);
                        redo = 1'b1;
                     end
                     n = n + 2'd1;
                  end
               end
            end
            atl_pkg::MODE_POPEN: begin
               s.in_paren = 1'b1;
               if (ch == "$") begin
                  s.mode = atl_pkg::MODE_NUM;
                  s.dec_value = '0;
                  s.hex_value = '0;
                  s.num_flags = '0;
               end else if (ch == 8'd0) begin
                  s.mode = atl_pkg::MODE_IDLE;
                  fail = 1'b1;
                  code = atl_pkg::ERR_BAD_REG;
               end else begin
                  s.mode = atl_pkg::MODE_REG;
                  s.name_chars = '0;
                  s.name_len   = '0;
                  s.name_last  = '0;
               end
            end
            atl_pkg::MODE_TILDE: begin
               if (ch == "~") s.mode = atl_pkg::MODE_COMMENT;
               else begin
                  s.mode = atl_pkg::MODE_IDLE;
                  fail = 1'b1;
                  code = atl_pkg::ERR_COMMENT;
               end
            end
            atl_pkg::MODE_COMMENT: begin
               if (ch == 8'd10) s.mode = atl_pkg::MODE_IDLE;
               else if (ch == 8'd0) begin
                  s.mode = atl_pkg::MODE_IDLE;
                  redo = 1'b1;
               end
            end
            default: do_idle = 1'b1;
         endcase

         if (fail) begin
            res[n] = atl_pkg::mk_result(atl_pkg::EV_ERROR, '0, 1'b0, '0, code);
            n = n + 2'd1;
            s.halted = 1'b1;
         end

         // start-of-token handling, also for a byte that just closed a token
         if (do_idle || redo) begin
            fail = 1'b0;
            cc = ch == "%" || ch == "$" || ch == "(" || ch == "," || ch == "~" ||
                 ch == "[" || ch == "]" || ch == ")" || ch == "+" || ch == "-" ||
                 ch == "*" || ch == "/";
            if (cc && s.limit != atl_pkg::LIMIT_NONE && s.place == s.limit) begin
               res[n] = atl_pkg::mk_result(atl_pkg::EV_COMPLETE, '0, 1'b0, s.fmt,
                                           atl_pkg::ERR_NONE);
               n = n + 2'd1;
               s.place = '0;
               s.limit = atl_pkg::LIMIT_NONE;
               s.fmt   = '0;
               s.slot  = '0;
            end
            opk = ch == "%" || ch == "$" || ch == "(";
            kind = (ch == "%") ? atl_pkg::KIND_R :
                   (ch == "$") ? atl_pkg::KIND_I : atl_pkg::KIND_DF;
            if (opk) begin
               if (!s.place[0]) begin
                  fail = 1'b1;
                  code = atl_pkg::ERR_MISPLACED;
               end else if (s.slot < 2'd3) begin
                  s.fmt  = s.fmt | (6'(kind) << {s.slot, 1'b0});
                  s.slot = s.slot + 2'd1;
               end
            end
            if (ch == 8'd0) begin
               res[n] = atl_pkg::mk_result(atl_pkg::EV_END, '0, 1'b0, '0,
                                           atl_pkg::ERR_NONE);
               n = n + 2'd1;
               s.halted = 1'b1;
            end else if (ch == " " || ch == 8'd9 || ch == 8'd10) begin
               s.mode = s.mode;
            end else if (opk) begin
               if (!fail) begin
                  if (ch == "(") s.mode = atl_pkg::MODE_POPEN;
                  else begin
                     s.in_paren = 1'b0;
                     if (ch == "%") begin
                        s.mode = atl_pkg::MODE_REG;
                        s.name_chars = '0;
                        s.name_len   = '0;
                        s.name_last  = '0;
                     end else begin
                        s.mode = atl_pkg::MODE_NUM;
                        s.dec_value = '0;
                        s.hex_value = '0;
                        s.num_flags = '0;
                     end
                  end
               end
            end else if (ch == ",") begin
               if (s.place == 3'd2 || s.place == 3'd4) s.place = s.place + 3'd1;
               else begin
                  fail = 1'b1;
                  code = atl_pkg::ERR_COMMA;
               end
            end else if (ch == "~") begin
               s.mode = atl_pkg::MODE_TILDE;
            end else if (cc) begin
               fail = 1'b1;
               code = atl_pkg::ERR_STRAY;
            end else if (atl_pkg::is_alpha(ch) || ch == "_") begin
               s.mode       = atl_pkg::MODE_NAME;
               s.name_chars = {32'd0, ch};
               s.name_len   = 8'd1;
               s.name_last  = ch;
            end else begin
               fail = 1'b1;
               code = atl_pkg::ERR_BAD_CHAR;
            end
            if (fail) begin
               res[n] = atl_pkg::mk_result(atl_pkg::EV_ERROR, '0, 1'b0, '0, code);
               n = n + 2'd1;
               s.halted = 1'b1;
            end
         end
      end

      st_in     = s;
      res_count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= atl_pkg::LEX_RESET;
      end else if (take) begin
         st_ff <= st_in;
      end
   end

endmodule

// ===== sv/atl_rspq.sv =====
// ----------------------------------------------------------------------------
// atl_rspq
// Result register bank: holds the results of one byte and plays them out.
// ----------------------------------------------------------------------------
module atl_rspq (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  atl_pkg::result_type res_in [atl_pkg::RES_MAX],
   input  logic [1:0]          count_in,
   output logic                can_load,
   atl_rsp_if.source           rsp
);

   atl_pkg::result_type buf_ff [atl_pkg::RES_MAX];
   logic [1:0] total_ff, total_in;
   logic [1:0] pos_ff, pos_in;
   logic       take;

   assign rsp.valid = pos_ff != total_ff;
   assign take      = rsp.valid && rsp.ready;
   // free when empty, or when the final beat leaves in this cycle
   assign can_load  = !rsp.valid || (take && pos_ff + 2'd1 == total_ff);

   assign rsp.event_res       = buf_ff[pos_ff].event_res;
   assign rsp.value           = buf_ff[pos_ff].value;
   assign rsp.mem_is_register = buf_ff[pos_ff].mem_is_register;
   assign rsp.operand_format  = buf_ff[pos_ff].operand_format;
   assign rsp.error_code      = buf_ff[pos_ff].error_code;
   assign rsp.last            = pos_ff + 2'd1 == total_ff;

   always_comb begin
      total_in = total_ff;
      pos_in   = pos_ff;
      if (load) begin
         total_in = count_in;
         pos_in   = '0;
      end else if (take) begin
         pos_in = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         pos_ff   <= '0;
      end else begin
         total_ff <= total_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < atl_pkg::RES_MAX; i++) buf_ff[i] <= res_in[i];
      end
   end

endmodule

// ===== sv/assembly_token_lexer_core.sv =====
// ----------------------------------------------------------------------------
// assembly_token_lexer_core
// Byte-stream lexer for assembly source text.
// ----------------------------------------------------------------------------
// Feed source text one byte per req beat; a zero byte ends the text. Each byte
// is taken at the accept edge by the lexer state register and per-byte logic,
// and the zero to three results it causes land in a small result register
// bank that plays them out one rsp beat per cycle while rsp is ready, the
// final one flagged by last. A new byte is taken in the same cycle the
// previous byte's final result leaves, so while rsp is ready a byte with one
// result (or none) sustains one byte per cycle; a byte with more results
// holds the input until its final result has left. Blanks and ~~ comments
// produce nothing. An instruction-complete event comes right before the token
// that follows a finished instruction; a trailing unfinished instruction, or
// a finished one ended by the zero byte, is never reported. After an end or
// error event every further byte is swallowed without results until reset.
// ----------------------------------------------------------------------------
module assembly_token_lexer_core #(
   parameter int NAME_MAX_LEN = atl_pkg::NAME_MAX_LEN_DEF,
   parameter int REG_COUNT    = atl_pkg::REG_COUNT_DEF
) (
   input  logic      clock,
   input  logic      reset,
   atl_req_if.sink   req_bus,
   atl_rsp_if.source rsp_bus
);

   atl_pkg::result_type res [atl_pkg::RES_MAX];
   logic [1:0] res_count;
   logic       can_load;
   logic       take;

   // accept a byte whenever the result bank is free for its results
   assign req_bus.ready = can_load;
   assign take          = req_bus.valid && can_load;

   atl_lexer #(
      .NAME_MAX_LEN (NAME_MAX_LEN),
      .REG_COUNT    (REG_COUNT)
   ) u_lexer (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .ch        (req_bus.ch),
      .res       (res),
      .res_count (res_count)
   );

   // hold results until each beat is taken
   atl_rspq u_rspq (
      .clock    (clock),
      .reset    (reset),
      .load     (take),
      .res_in   (res),
      .count_in (res_count),
      .can_load (can_load),
      .rsp      (rsp_bus)
   );

endmodule

// ===== sv/atl_checker.sv =====
// ----------------------------------------------------------------------------
// atl_checker
// Port-level checks of the token lexer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assembly_token_lexer_core_defines.svh"

module atl_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_event_res,
   input logic [3:0] rsp_error_code,
   input logic       rsp_last
);

   `ATL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_event_res), "stalled rsp beat changed")
   `ATL_ASSERT_NEXT(a_halt_quiet, clock, reset, rsp_valid && rsp_ready && (rsp_event_res == atl_pkg::EV_END || rsp_event_res == atl_pkg::EV_ERROR), !rsp_valid, "result after end or error")
   `ATL_ASSERT_NOW(a_err_code, clock, reset, rsp_valid && rsp_event_res == atl_pkg::EV_ERROR, rsp_error_code != atl_pkg::ERR_NONE && rsp_last, "error beat lacks code or last")
   `ATL_ASSERT_NOW(a_no_code, clock, reset, rsp_valid && rsp_event_res != atl_pkg::EV_ERROR, rsp_error_code == atl_pkg::ERR_NONE, "code on non-error beat")

endmodule

bind assembly_token_lexer_core atl_checker u_atl_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_event_res  (rsp_bus.event_res),
   .rsp_error_code (rsp_bus.error_code),
   .rsp_last       (rsp_bus.last)
);
